>>> design/cfcq_pkg.sv
// Package for the cancellable frame callback queue.
// Holds the queue sizing constants, the request and result codes and the shared types.
// Has no dependencies. The top level and cfcq_ctrl import it; cfcq_ram does not.
`default_nettype none

package cfcq_pkg;

  // Queue sizing.
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;

  // Input item kinds. Code 3 has no meaning and is ignored.
  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2
  } req_e;

  // Result item kinds.
  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_READ,
    ST_CHECK
  } state_e;

  // One queue slot as stored in the slot memory.
  typedef struct packed {
    logic              cancelled;
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result item on its way to the output register.
  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] granted_id;
    logic [DATA_W-1:0] fired_handle;
    logic              last;
  } result_t;

  // Port from the sequencer to the slot memory.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> design/cancellable_frame_callback_queue.sv
// Top level of the cancellable frame callback queue.
// Depends on cfcq_pkg, cfcq_ram and cfcq_ctrl; holds the output register.
//
//   Channel  Handshake                 Payload
//   in       in_valid_i / in_ready_o   req_type_i, handle_i, target_id_i
//   out      out_valid_o / out_ready_i result_kind_o, granted_id_o, fired_handle_o, last_o
//
// A cancel reads and checks slots from the head until one matches its ID or the last is done.
// A tick reads and checks every queued slot in turn through the one slot memory read port
// shared by the scan. A stalled output holds an alloc or a tick while a result waits.
// Reset empties the queue and sets the next ID to 1; the slot memory is not cleared.
`default_nettype none

module cancellable_frame_callback_queue import cfcq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [DATA_W-1:0] handle_i,
  input  wire logic [DATA_W-1:0] target_id_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             result_kind_o,
  output logic [DATA_W-1:0]      granted_id_o,
  output logic [DATA_W-1:0]      fired_handle_o,
  output logic                   last_o
);

  mem_req_t mem_req;
  entry_t   rd_entry;
  logic     out_free;
  logic     push;
  result_t  res;
  logic     out_valid_q, out_valid_d;
  result_t  out_q;

  // Slot memory.
  cfcq_ram #(
    .Width (ENTRY_W),
    .Depth (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_entry)
  );

  // Sequencer.
  cfcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .handle_i    (handle_i),
    .target_id_i (target_id_i),
    .mem_o       (mem_req),
    .rd_entry_i  (rd_entry),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign granted_id_o   = out_q.granted_id;
  assign fired_handle_o = out_q.fired_handle;
  assign last_o         = out_q.last;

endmodule

`default_nettype wire

>>> design/cfcq_ram.sv
// Simple dual-port slot memory with one write port and one registered read port.
// Generic over word width and depth. Has no package dependency.
`default_nettype none

module cfcq_ram #(
  parameter int Width = 65,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/cfcq_ctrl.sv
// Sequencer of the callback queue: takes items, walks the slot memory and builds results.
// Depends on cfcq_pkg. Drives the slot memory port and pushes results to the output register.
`default_nettype none

module cfcq_ctrl import cfcq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [DATA_W-1:0] handle_i,
  input  wire logic [DATA_W-1:0] target_id_i,
  output mem_req_t               mem_o,
  input  wire entry_t            rd_entry_i,
  input  wire logic              out_free_i,
  output logic                   push_o,
  output result_t                res_o
);

  state_e            state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [DATA_W-1:0] handle_q, handle_d;
  logic [DATA_W-1:0] target_q, target_d;
  logic [DATA_W-1:0] ticket_q, ticket_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  live_q, live_d;
  logic [CNT_W-1:0]  remain_q, remain_d;

  logic accept;
  logic id_hit;
  logic at_end;
  logic is_full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Shared compare unit: ID match and end-of-queue test for the current slot.
  assign id_hit  = (rd_entry_i.id == target_q);
  assign at_end  = ((CNT_W'(idx_q) + CNT_W'(1)) == used_q);
  assign is_full = (used_q == CNT_W'(QUEUE_DEPTH));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_ALLOC:  state_d = ST_ALLOC;
            REQ_CANCEL: state_d = (used_q == '0) ? ST_IDLE : ST_READ;
            REQ_TICK:   state_d = (used_q == '0) ? ST_IDLE : ST_READ;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      ST_READ: state_d = ST_CHECK;
      ST_CHECK: begin
        if (op_q == REQ_CANCEL) begin
          state_d = (id_hit || at_end) ? ST_IDLE : ST_READ;
        end else if (!rd_entry_i.cancelled && !out_free_i) begin
          state_d = ST_CHECK;
        end else begin
          state_d = at_end ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_d     = op_q;
    handle_d = handle_q;
    target_d = target_q;
    ticket_d = ticket_q;
    idx_d    = idx_q;
    used_d   = used_q;
    live_d   = live_q;
    remain_d = remain_q;

    mem_o    = '0;
    push_o   = 1'b0;
    res_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        // Latch the item and start any scan at the head of the queue.
        if (accept) begin
          op_d     = req_type_i;
          handle_d = handle_i;
          target_d = target_id_i;
          idx_d    = '0;
          remain_d = live_q;
        end
      end
      ST_ALLOC: begin
        // Grant a slot and an ID, or report a full queue.
        if (out_free_i) begin
          push_o = 1'b1;
          res_o.last = 1'b1;
          if (is_full) begin
            res_o.kind = KIND_FULL;
          end else begin
            res_o.kind       = KIND_GRANT;
            res_o.granted_id = ticket_q;
            mem_o.we               = 1'b1;
            mem_o.waddr            = used_q[IDX_W-1:0];
            mem_o.wdata.cancelled  = 1'b0;
            mem_o.wdata.id         = ticket_q;
            mem_o.wdata.handle     = handle_q;
            used_d   = used_q + CNT_W'(1);
            live_d   = live_q + CNT_W'(1);
            ticket_d = (ticket_q == '1) ? DATA_W'(1) : ticket_q + DATA_W'(1);
          end
        end
      end
      ST_READ: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = idx_q;
      end
      ST_CHECK: begin
        if (op_q == REQ_CANCEL) begin
          // Mark the first matching slot; an already cancelled one stays as it is.
          if (id_hit) begin
            if (!rd_entry_i.cancelled) begin
              mem_o.we              = 1'b1;
              mem_o.waddr           = idx_q;
              mem_o.wdata           = rd_entry_i;
              mem_o.wdata.cancelled = 1'b1;
              live_d = live_q - CNT_W'(1);
            end
          end else if (!at_end) begin
            idx_d = idx_q + IDX_W'(1);
          end
        end else if (rd_entry_i.cancelled || out_free_i) begin
          // Fire a live slot, then move on; the queue empties after the last slot.
          if (!rd_entry_i.cancelled) begin
            push_o             = 1'b1;
            res_o.kind         = KIND_FIRED;
            res_o.fired_handle = rd_entry_i.handle;
            res_o.last         = (remain_q == CNT_W'(1));
            remain_d           = remain_q - CNT_W'(1);
          end
          if (at_end) begin
            used_d = '0;
            live_d = '0;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      live_q   <= '0;
      ticket_q <= DATA_W'(1);
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      live_q   <= live_d;
      ticket_q <= ticket_d;
    end
  end

  // Item payload and scan position.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    handle_q <= handle_d;
    target_q <= target_d;
    idx_q    <= idx_d;
    remain_q <= remain_d;
  end

endmodule

`default_nettype wire
